### rtl/pnd_pkg.sv
// Package for the packed name decoder: result kinds, queue entry type,
// queue sizing and the 6-bit character code table.
// No dependencies.
package pnd_pkg;

  // Result kinds as they appear on the result channel
  typedef enum logic [1:0] {
    KIND_PREFIX = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } res_t;

  // Results caused by one input byte (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;

  // Packed name header and code constants
  localparam logic [5:0] HdrThresh = 6'h38;
  localparam logic [5:0] CodeEnd   = 6'h00;

  // Character set lookup for codes 1..63; 48 and up (and 0) give underscore
  function automatic logic [7:0] map_code(input logic [5:0] code);
    logic [7:0] ch;
    ch = 8'h5F;
    priority if (code == 6'd1)  ch = 8'h20;
    else if (code == 6'd2)      ch = 8'h23;
    else if (code == 6'd3)      ch = 8'h24;
    else if (code == 6'd4)      ch = 8'h28;
    else if (code == 6'd5)      ch = 8'h29;
    else if (code == 6'd6)      ch = 8'h2D;
    else if (code == 6'd7)      ch = 8'h2E;
    else if (code == 6'd8)      ch = 8'h2F;
    else if (code == 6'd9)      ch = 8'h3F;
    else if (code >= 6'd10 && code <= 6'd19) ch = 8'h30 + {2'b00, code - 6'd10};
    else if (code == 6'd20)     ch = 8'h5F;
    else if (code >= 6'd21 && code <= 6'd46) ch = 8'h61 + {2'b00, code - 6'd21};
    else if (code == 6'd47)     ch = 8'h7E;
    else                        ch = 8'h5F;
    return ch;
  endfunction

endpackage

### rtl/pnd_front.sv
// Front part of the packed name decoder: accepts bytes, tracks name state
// and splits each byte into one or two results for the queue.
// Depends on pnd_pkg.
module pnd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_data_byte,
  input  logic            in_name_start,
  input  logic            q_full,
  output logic            in_stall,
  output logic            push,
  output pnd_pkg::entry_t push_entry
);
  import pnd_pkg::*;

  logic       active_r, active_nxt;
  logic       hdr_pend_r, hdr_pend_nxt;
  logic [4:0] hdr_low_r, hdr_low_nxt;
  logic [3:0] carry_bits_r, carry_bits_nxt;
  logic [2:0] carry_cnt_r, carry_cnt_nxt;

  logic        accept;
  logic        produce;
  logic [2:0]  cnt;
  logic [11:0] acc;
  logic [3:0]  total;
  logic [3:0]  rem;
  logic [5:0]  code0;
  logic [5:0]  code1;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && produce;

  // Classify the byte and work out the next name state
  always_comb begin
    active_nxt     = active_r;
    hdr_pend_nxt   = hdr_pend_r;
    hdr_low_nxt    = hdr_low_r;
    carry_bits_nxt = carry_bits_r;
    carry_cnt_nxt  = carry_cnt_r;
    produce        = 1'b0;
    push_entry     = '0;
    push_entry.r0.kind = KIND_PREFIX;
    push_entry.r1.kind = KIND_PREFIX;

    cnt   = (carry_cnt_r > 3'd4) ? 3'd4 : carry_cnt_r;
    acc   = {8'h00, carry_bits_r} | ({4'h0, in_data_byte} << cnt);
    total = {1'b0, cnt} + 4'd8;
    rem   = total - 4'd6;
    code0 = acc[5:0];
    code1 = acc[11:6];

    if (in_name_start) begin
      active_nxt     = 1'b1;
      hdr_pend_nxt   = 1'b0;
      carry_bits_nxt = '0;
      carry_cnt_nxt  = '0;
      if (in_data_byte[5:0] >= HdrThresh) begin
        // header byte: low prefix bits now, result with the next byte
        hdr_pend_nxt = 1'b1;
        hdr_low_nxt  = {in_data_byte[7:6], in_data_byte[2:0]};
      end else begin
        produce            = 1'b1;
        push_entry.two     = 1'b1;
        push_entry.r0.kind = KIND_PREFIX;
        push_entry.r0.value = 8'h00;
        if (in_data_byte[5:0] == CodeEnd) begin
          push_entry.r1.kind  = KIND_END;
          push_entry.r1.value = 8'h00;
          active_nxt          = 1'b0;
        end else begin
          push_entry.r1.kind  = KIND_CHAR;
          push_entry.r1.value = map_code(in_data_byte[5:0]);
          carry_bits_nxt      = {2'b00, in_data_byte[7:6]};
          carry_cnt_nxt       = 3'd2;
        end
      end
    end else if (!active_r) begin
      // outside a name: ignored
      produce = 1'b0;
    end else if (hdr_pend_r) begin
      // second header byte completes the prefix length
      produce             = 1'b1;
      hdr_pend_nxt        = 1'b0;
      push_entry.r0.kind  = KIND_PREFIX;
      push_entry.r0.value = {in_data_byte[2:0], hdr_low_r};
      carry_bits_nxt      = in_data_byte[7:4];
      carry_cnt_nxt       = 3'd4;
    end else begin
      // code stream: one or two 6-bit codes
      produce = 1'b1;
      if (code0 == CodeEnd) begin
        push_entry.r0.kind  = KIND_END;
        push_entry.r0.value = 8'h00;
        active_nxt          = 1'b0;
        carry_bits_nxt      = '0;
        carry_cnt_nxt       = '0;
      end else begin
        push_entry.r0.kind  = KIND_CHAR;
        push_entry.r0.value = map_code(code0);
        if (total >= 4'd12) begin
          push_entry.two = 1'b1;
          carry_bits_nxt = '0;
          carry_cnt_nxt  = '0;
          if (code1 == CodeEnd) begin
            push_entry.r1.kind  = KIND_END;
            push_entry.r1.value = 8'h00;
            active_nxt          = 1'b0;
          end else begin
            push_entry.r1.kind  = KIND_CHAR;
            push_entry.r1.value = map_code(code1);
          end
        end else begin
          carry_bits_nxt = acc[9:6];
          carry_cnt_nxt  = rem[2:0];
        end
      end
    end
  end

  // Name state registers, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      hdr_pend_r   <= 1'b0;
      hdr_low_r    <= '0;
      carry_bits_r <= '0;
      carry_cnt_r  <= '0;
    end else if (accept) begin
      active_r     <= active_nxt;
      hdr_pend_r   <= hdr_pend_nxt;
      hdr_low_r    <= hdr_low_nxt;
      carry_bits_r <= carry_bits_nxt;
      carry_cnt_r  <= carry_cnt_nxt;
    end
  end

endmodule

### rtl/pnd_queue.sv
// Short queue of result groups between front and back.
// Depends on pnd_pkg.
module pnd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pnd_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output pnd_pkg::entry_t head
);
  import pnd_pkg::*;

  entry_t           mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW:0]   count_r;

  assign full  = (count_r == (QPtrW+1)'(QDepth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/pnd_back.sv
// Back part of the packed name decoder: walks each queued group one result
// per cycle into the output register unless out_stall holds it. Depends on pnd_pkg.
module pnd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  pnd_pkg::entry_t head,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value,
  output logic            out_last
);
  import pnd_pkg::*;

  logic       idx_r;
  logic       out_valid_r;
  kind_t      kind_r;
  logic [7:0] value_r;
  logic       last_r;

  logic load;
  logic fin;
  res_t sel;

  assign load = !q_empty && (!out_valid_r || !out_stall);
  assign sel  = idx_r ? head.r1 : head.r0;
  assign fin  = idx_r || !head.two;
  assign pop  = load && fin;

  // Result index within the group and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= !fin;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload, held while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= sel.kind;
      value_r <= sel.value;
      last_r  <= fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

### rtl/packed_name_decoder_unit.sv
// Top level of the packed name decoder: front, queue and back.
// Depends on pnd_pkg, pnd_front, pnd_queue, pnd_back.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one heap byte per transaction
//   with in_name_start set on the first byte of each name. Result channel
//   (out_valid/out_stall) carries kind/value/last; last marks the final
//   result produced by one input byte.
//   A name yields a keep-prefix result (0 if no header), then characters,
//   then an end result. A header byte itself yields nothing.
// Path: an accepted byte's results go into the queue, then the output register.
// Throughput: one byte per cycle while each byte yields one result and out_stall
//   is low; a byte yielding two results passes them one after the other through
//   the single output register, so such bytes can fill the queue and raise in_stall.
// Reset: synchronous active-low rst_n clears name state, the queue and the
//   output valid; the block is outside any name afterwards.
// Stall: out_stall holds the output register; the two-entry queue absorbs
//   bytes until full, then in_stall is raised.
module packed_name_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_name_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);
  import pnd_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  entry_t head;

  // Byte intake and classification
  pnd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_name_start (in_name_start),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Decoupling queue
  pnd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  // Result sequencing and output register
  pnd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule
